FILE: rtl/assert_macros.svh
// Assertion macros shared by the rank block RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbcs assertion failed");
`define RBCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbcs assertion failed");
`else
`define RBCS_ASSERT_IMP(lbl, ante, cons)
`define RBCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rbcs_pkg.sv
// Package for the rank block: widths, state encoding, cell control struct.
// No dependencies.
package rbcs_pkg;

  localparam int VAL_W            = 32;
  localparam int RANK_W           = 7;
  localparam int CNT_W            = 7;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef enum logic [1:0] {
    S_LOAD,
    S_UPD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             cap;
    logic             upd;
    logic             wr;
    logic             shift;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

FILE: rtl/rbcs_cell.sv
// One cell of the rank chain: holds a value and its running rank.
// Depends on rbcs_pkg.
module rbcs_cell
  import rbcs_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] cmp_val,
  input  logic signed [VAL_W-1:0] wr_val,
  input  logic [RANK_W-1:0]       wr_rank,
  input  logic [RANK_W-1:0]       rank_in,
  output logic [RANK_W-1:0]       rank_out,
  output logic                    lt_out
);

  logic signed [VAL_W-1:0] val_r;
  logic [RANK_W-1:0]       rank_r;
  logic                    lt_r;
  logic                    gt_r;
  logic                    used;
  logic                    here;

  assign used = CNT_W'(IDX) < ctl.count;
  assign here = CNT_W'(IDX) == ctl.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      gt_r <= 1'b0;
    end else if (ctl.cap) begin
      lt_r <= used && (val_r < cmp_val);
      gt_r <= used && (val_r > cmp_val);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && ctl.wr && here) begin
      val_r  <= wr_val;
      rank_r <= wr_rank;
    end else if (ctl.upd && gt_r) begin
      rank_r <= rank_r + RANK_W'(1);
    end else if (ctl.shift) begin
      rank_r <= rank_in;
    end
  end

  assign rank_out = rank_r;
  assign lt_out   = lt_r;

endmodule

FILE: rtl/rbcs_popcount.sv
// Adder tree counting set flags across the cell row.
// Depends on rbcs_pkg.
module rbcs_popcount
  import rbcs_pkg::*;
#(
  parameter int N = MAX_ELEMENTS_DEF
) (
  input  logic [N-1:0]      bits,
  output logic [RANK_W-1:0] total
);

  localparam int LVLS = $clog2(N);
  localparam int PAD  = 1 << LVLS;

  logic [RANK_W-1:0] sums [LVLS+1][PAD];

  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int k = 0; k < PAD; k++) begin
        sums[l][k] = '0;
      end
    end
    for (int k = 0; k < N; k++) begin
      sums[0][k] = RANK_W'(bits[k]);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int k = 0; k < (PAD >> (l + 1)); k++) begin
        sums[l+1][k] = sums[l][2*k] + sums[l][2*k+1];
      end
    end
  end

  assign total = sums[LVLS][0];

endmodule

FILE: rtl/rank_by_counting_smaller.sv
// Rank transform: each input beat is compared against all cells (S_LOAD), then counted and written
// (S_UPD); no beat is taken in S_UPD. The first rank is valid in S_OUT, entered from S_UPD after
// the last beat; ranks then leave one per cycle while out_ready is high, from the head of the cell
// chain, n beats for n stored elements; the next set is accepted the cycle after the final rank is taken.
// Reset (rst_n low, synchronous) empties the set and clears the overflow flag;
// stored values are not cleared. Depends on rbcs_pkg, rbcs_cell, rbcs_popcount.
`include "assert_macros.svh"
module rank_by_counting_smaller
  import rbcs_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RANK_W-1:0]       out_rank,
  output logic                    out_last_out,
  output logic                    out_overflow
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    last_r, last_nxt;
  logic                    wr_r, wr_nxt;
  logic signed [VAL_W-1:0] x_r;
  cell_ctl_t               ctl;
  logic [MAX_ELEMENTS-1:0] lt_bits;
  logic [RANK_W-1:0]       pop;
  logic [RANK_W-1:0]       new_rank;
  logic [RANK_W-1:0]       ranks [MAX_ELEMENTS+1];
  logic                    in_acc;
  logic                    out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      wr_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
      wr_r    <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    wr_nxt    = wr_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl       = '0;
    ctl.count = cnt_r;
    ctl.wr    = wr_r;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cap   = 1'b1;
          last_nxt  = in_last_in;
          wr_nxt    = cnt_r < CNT_W'(MAX_ELEMENTS);
          ovf_nxt   = ovf_r || (cnt_r >= CNT_W'(MAX_ELEMENTS));
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // a dropped beat leaves the stored ranks alone
        ctl.upd = wr_r;
        if (wr_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = last_r ? S_OUT : S_LOAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign new_rank = pop + RANK_W'(1);
  assign ranks[MAX_ELEMENTS] = '0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    rbcs_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cmp_val  (in_value),
      .wr_val   (x_r),
      .wr_rank  (new_rank),
      .rank_in  (ranks[i+1]),
      .rank_out (ranks[i]),
      .lt_out   (lt_bits[i])
    );
  end

  rbcs_popcount #(.N(MAX_ELEMENTS)) u_pop (
    .bits  (lt_bits),
    .total (pop)
  );

  assign out_rank     = ranks[0];
  assign out_last_out = cnt_r == CNT_W'(1);
  assign out_overflow = out_last_out && ovf_r;

  `RBCS_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `RBCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_ELEMENTS))
  `RBCS_ASSERT_IMP(a_ovf_full, ovf_r && state_r == S_LOAD, cnt_r == CNT_W'(MAX_ELEMENTS))
  `RBCS_ASSERT_NXT(a_set_done, out_acc && out_last_out, in_ready && cnt_r == '0 && !ovf_r)

endmodule
